>>> rtl/cvtc_pkg.sv
// Shared types and constants for the CSV value token classifier.
`timescale 1ns / 1ps
`default_nettype none

package cvtc_pkg;

   // one more than the longest value, terminator excluded, before the overflow item fires
   localparam int MAX_VALUE_LEN = 64;
   localparam int CNT_W         = $clog2(MAX_VALUE_LEN);
   localparam int CNT_EXT_W     = 13;
   localparam int LEN_W         = 6;
   localparam int LEN_SAT       = 63;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_VTAB  = 8'd11;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_DOT   = 8'd46;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_UC_A  = 8'd65;
   localparam logic [7:0] CHAR_UC_Z  = 8'd90;
   localparam logic [7:0] CHAR_LC_A  = 8'd97;
   localparam logic [7:0] CHAR_LC_Z  = 8'd122;

   typedef enum logic [2:0] {
      ST_INITIAL = 3'd0,
      ST_MINUS   = 3'd1,
      ST_NUMBER  = 3'd2,
      ST_FLOAT   = 3'd3,
      ST_DOT     = 3'd4,
      ST_STRING  = 3'd5
   } state_type;

   typedef enum logic [2:0] {
      CL_OTHER  = 3'd0,
      CL_DIGIT  = 3'd1,
      CL_LETTER = 3'd2,
      CL_DOT    = 3'd3,
      CL_SPACE  = 3'd4,
      CL_VTAB   = 3'd5,
      CL_TAB    = 3'd6,
      CL_MINUS  = 3'd7
   } class_type;

   typedef enum logic [1:0] {
      VT_INTEGER = 2'd0,
      VT_FLOAT   = 2'd1,
      VT_STRING  = 2'd2
   } vtype_type;

   typedef struct packed {
      state_type          dfa_state;
      logic [CNT_W-1:0]   char_count;
      logic [31:0]        magnitude_acc;
      logic               negative_flag;
      logic               discarding;
   } lexer_state_type;

   typedef struct packed {
      vtype_type          val_kind;
      logic signed [31:0] int_value;
      logic [LEN_W-1:0]   value_length;
      logic               overflow_error;
   } result_type;

   localparam lexer_state_type LEXER_CLEAR = '{
      dfa_state:     ST_INITIAL,
      char_count:    '0,
      magnitude_acc: '0,
      negative_flag: 1'b0,
      discarding:    1'b0
   };

endpackage

`default_nettype wire

>>> rtl/cvtc_step.sv
// Per-character lexer step: classification, DFA transition and result forming.
`timescale 1ns / 1ps
`default_nettype none

module cvtc_step (
   input  wire logic [7:0]              char_code,
   input  wire cvtc_pkg::lexer_state_type cur,
   output cvtc_pkg::lexer_state_type    nxt,
   output logic                         emit,
   output cvtc_pkg::result_type         result
);

   cvtc_pkg::class_type        cls;
   cvtc_pkg::state_type        s_next;
   logic                       is_term;
   logic [cvtc_pkg::CNT_EXT_W-1:0] count_ext;
   logic [cvtc_pkg::LEN_W-1:0] len_sat;
   logic [31:0]                digit_val;
   logic [31:0]                times_ten;

   always_comb begin
      if (char_code == cvtc_pkg::CHAR_VTAB) begin
         cls = cvtc_pkg::CL_VTAB;
      end else if (char_code == cvtc_pkg::CHAR_TAB) begin
         cls = cvtc_pkg::CL_TAB;
      end else if (char_code == cvtc_pkg::CHAR_SPACE) begin
         cls = cvtc_pkg::CL_SPACE;
      end else if (char_code == cvtc_pkg::CHAR_MINUS) begin
         cls = cvtc_pkg::CL_MINUS;
      end else if (char_code == cvtc_pkg::CHAR_DOT) begin
         cls = cvtc_pkg::CL_DOT;
      end else if (char_code inside {[cvtc_pkg::CHAR_ZERO:cvtc_pkg::CHAR_NINE]}) begin
         cls = cvtc_pkg::CL_DIGIT;
      end else if (char_code inside {[cvtc_pkg::CHAR_UC_A:cvtc_pkg::CHAR_UC_Z],
                                     [cvtc_pkg::CHAR_LC_A:cvtc_pkg::CHAR_LC_Z]}) begin
         cls = cvtc_pkg::CL_LETTER;
      end else begin
         cls = cvtc_pkg::CL_OTHER;
      end
   end

   always_comb begin
      case (cls)
         cvtc_pkg::CL_DIGIT: begin
            if (cur.dfa_state inside {cvtc_pkg::ST_INITIAL, cvtc_pkg::ST_MINUS,
                                      cvtc_pkg::ST_NUMBER}) begin
               s_next = cvtc_pkg::ST_NUMBER;
            end else if (cur.dfa_state inside {cvtc_pkg::ST_FLOAT, cvtc_pkg::ST_DOT}) begin
               s_next = cvtc_pkg::ST_FLOAT;
            end else begin
               s_next = cvtc_pkg::ST_STRING;
            end
         end
         cvtc_pkg::CL_DOT: begin
            if (cur.dfa_state inside {cvtc_pkg::ST_INITIAL, cvtc_pkg::ST_MINUS,
                                      cvtc_pkg::ST_NUMBER}) begin
               s_next = cvtc_pkg::ST_DOT;
            end else begin
               s_next = cvtc_pkg::ST_STRING;
            end
         end
         cvtc_pkg::CL_MINUS: begin
            s_next = (cur.dfa_state == cvtc_pkg::ST_INITIAL) ? cvtc_pkg::ST_MINUS
                                                             : cvtc_pkg::ST_STRING;
         end
         cvtc_pkg::CL_VTAB: begin
            s_next = cvtc_pkg::ST_INITIAL;
         end
         default: begin
            s_next = cvtc_pkg::ST_STRING;
         end
      endcase
   end

   assign is_term   = (char_code == cvtc_pkg::CHAR_LF) || (char_code == cvtc_pkg::CHAR_CR) ||
                      (char_code == cvtc_pkg::CHAR_NUL);
   assign count_ext = cvtc_pkg::CNT_EXT_W'(cur.char_count);
   assign len_sat   = (count_ext > cvtc_pkg::CNT_EXT_W'(cvtc_pkg::LEN_SAT))
                      ? cvtc_pkg::LEN_W'(cvtc_pkg::LEN_SAT) : count_ext[cvtc_pkg::LEN_W-1:0];
   assign digit_val = {24'd0, char_code - cvtc_pkg::CHAR_ZERO};
   // x10 as shift-and-add, wrapping at 32 bits
   assign times_ten = {cur.magnitude_acc[28:0], 3'b000} + {cur.magnitude_acc[30:0], 1'b0};

   always_comb begin
      nxt                   = cur;
      emit                  = 1'b0;
      result.val_kind       = cvtc_pkg::VT_STRING;
      result.int_value      = '0;
      result.value_length   = len_sat;
      result.overflow_error = 1'b0;

      if (is_term) begin
         nxt  = cvtc_pkg::LEXER_CLEAR;
         // the terminator after an overflow closes the value silently
         emit = !cur.discarding;
         if (cur.dfa_state == cvtc_pkg::ST_NUMBER) begin
            result.val_kind  = cvtc_pkg::VT_INTEGER;
            result.int_value = cur.negative_flag ? (32'sd0 - $signed(cur.magnitude_acc))
                                                 : $signed(cur.magnitude_acc);
         end else if (cur.dfa_state == cvtc_pkg::ST_FLOAT) begin
            result.val_kind = cvtc_pkg::VT_FLOAT;
         end
      end else if (cur.discarding) begin
         nxt = cur;
      end else if (cur.char_count == cvtc_pkg::CNT_W'(cvtc_pkg::MAX_VALUE_LEN - 1)) begin
         emit                  = 1'b1;
         result.overflow_error = 1'b1;
         nxt.discarding        = 1'b1;
      end else begin
         nxt.dfa_state  = s_next;
         nxt.char_count = cur.char_count + 1'b1;
         if (cls == cvtc_pkg::CL_VTAB) begin
            nxt.magnitude_acc = '0;
            nxt.negative_flag = 1'b0;
         end else if (cls == cvtc_pkg::CL_MINUS && cur.dfa_state == cvtc_pkg::ST_INITIAL) begin
            nxt.magnitude_acc = '0;
            nxt.negative_flag = 1'b1;
         end else if (cls == cvtc_pkg::CL_DIGIT && s_next == cvtc_pkg::ST_NUMBER) begin
            nxt.magnitude_acc = times_ten + digit_val;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/csv_value_token_classifier.sv
// Top level: input register, lexer step, result register.
// A character item is taken into the input register, passed through the lexer
// step, and any result goes through the result register onto the result channel.
// Throughput: one character item per cycle; the combinational step with its
// x10 accumulate bounds the rate, and stalls only follow rsp_tready.
// Reset (synchronous, active high) empties both registers and returns the
// DFA to initial with count, accumulator and flags cleared.
`timescale 1ns / 1ps
`default_nettype none

module csv_value_token_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] int_value, [37:32] value_length, pad
   output logic [2:0]       rsp_tuser    // [1:0] val_kind, [2] overflow_error
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                char_ff;
   logic                      out_valid_ff, out_valid_in;
   cvtc_pkg::result_type      result_ff;
   cvtc_pkg::lexer_state_type state_ff, state_in;
   cvtc_pkg::result_type      step_result;
   logic                      step_emit;
   logic                      advance;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? step_emit : (out_valid_ff && !rsp_tready);

   cvtc_step u_step (
      .char_code (char_ff),
      .cur       (state_ff),
      .nxt       (state_in),
      .emit      (step_emit),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= cvtc_pkg::LEXER_CLEAR;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
      end
      if (advance && step_emit) begin
         result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, result_ff.value_length, result_ff.int_value};
   assign rsp_tuser  = {result_ff.overflow_error, result_ff.val_kind};

   a_overflow_is_string: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == cvtc_pkg::VT_STRING
                                     && rsp_tdata[31:0] == 32'd0)
      else $error("overflow item without string type or zero value");

   a_non_int_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != cvtc_pkg::VT_INTEGER |-> rsp_tdata[31:0] == 32'd0)
      else $error("non-integer item carries a value");

   a_discard_at_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.discarding |->
         state_ff.char_count == cvtc_pkg::CNT_W'(cvtc_pkg::MAX_VALUE_LEN - 1))
      else $error("discarding with count below the limit");

   a_held_char: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(char_ff))
      else $error("pending character lost while stalled");

   a_stalled_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(result_ff) && !$past(advance))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
